@@ src/wpp_pkg.sv @@
// ----------------------------------------------------------------------------
// wpp_pkg
// Shared types, codes and constants of the 8-bit mono WAV parser.
// ----------------------------------------------------------------------------
package wpp_pkg;

  localparam int unsigned DataW = 32;

  localparam logic [DataW-1:0] RATE_RESET    = 32'd8000;
  localparam logic [DataW-1:0] SAMPLES_RESET = 32'd0;

  // register indexes
  localparam logic REG_RATE    = 1'b0;
  localparam logic REG_SAMPLES = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RIFF     = 3'd1;
  localparam logic [2:0] ST_FMT_TAG  = 3'd2;
  localparam logic [2:0] ST_FMT_LEN  = 3'd3;
  localparam logic [2:0] ST_FORMAT   = 3'd4;
  localparam logic [2:0] ST_DATA_TAG = 3'd5;
  localparam logic [2:0] ST_TRUNC    = 3'd6;

  // tag selectors
  localparam logic [1:0] TAG_RIFF = 2'd0;
  localparam logic [1:0] TAG_WAVE = 2'd1;
  localparam logic [1:0] TAG_FMT  = 2'd2;
  localparam logic [1:0] TAG_DATA = 2'd3;

  // tags, first byte in the low lane
  localparam logic [31:0] TAGW_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAGW_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAGW_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAGW_DATA = 32'h6174_6164;

  localparam logic [7:0] SIGN_FLIP = 8'h80;

  typedef struct packed {
    logic [DataW-1:0] rate;
    logic [DataW-1:0] samples;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [7:0] sample;
    logic [DataW-1:0]  count;
    logic [2:0]        status;
    logic              last;
  } res_t;

  function automatic logic [7:0] tag_byte(logic [1:0] which, logic [1:0] idx);
    logic [31:0] word;
    unique case (which)
      TAG_RIFF: word = TAGW_RIFF;
      TAG_WAVE: word = TAGW_WAVE;
      TAG_FMT:  word = TAGW_FMT;
      default:  word = TAGW_DATA;
    endcase
    return word[{idx, 3'b000} +: 8];
  endfunction

endpackage

@@ src/wpp_regs.sv @@
// ----------------------------------------------------------------------------
// wpp_regs
// Configuration registers behind the bus port: sample rate and sample count.
// ----------------------------------------------------------------------------
module wpp_regs
  import wpp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_RATE:    cfg_nxt.rate    = pwdata;
        REG_SAMPLES: cfg_nxt.samples = pwdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rate    <= RATE_RESET;
      cfg_r.samples <= SAMPLES_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RATE:    prdata = cfg_r.rate;
      REG_SAMPLES: prdata = cfg_r.samples;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ src/wpp_core.sv @@
// ----------------------------------------------------------------------------
// wpp_core
// Parse state and the single-beat step: tag checks, field capture, counters.
// ----------------------------------------------------------------------------
module wpp_core
  import wpp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] byte_value,
  input  logic       no_byte,
  input  logic       start_of_file,
  input  cfg_t       cfg,
  output logic       res_valid,
  output res_t       res
);

  localparam logic [2:0] PH_MAIN     = 3'd0;
  localparam logic [2:0] PH_FMT_HDR  = 3'd1;
  localparam logic [2:0] PH_FMT_BODY = 3'd2;
  localparam logic [2:0] PH_FMT_SKIP = 3'd3;
  localparam logic [2:0] PH_DATA_HDR = 3'd4;
  localparam logic [2:0] PH_SAMPLES  = 3'd5;
  localparam logic [2:0] PH_DONE     = 3'd6;
  localparam logic [2:0] PH_HALTED   = 3'd7;

  logic [2:0]       ph_r, ph_nxt;
  logic [DataW-1:0] pos_r, pos_nxt;
  logic             ok_r, ok_nxt;
  logic [DataW-1:0] asm_r, asm_nxt;
  logic             fmt_ext_r, fmt_ext_nxt;
  logic [DataW-1:0] skip_m1_r, skip_m1_nxt;
  logic [DataW-1:0] left_r, left_nxt;

  logic [2:0]       ph;
  logic [DataW-1:0] pos;
  logic [DataW-1:0] pos_inc;
  logic             ok;
  logic             chk;
  logic [DataW-1:0] shifted;

  always_comb begin
    ph      = start_of_file ? PH_MAIN : ph_r;
    pos     = start_of_file ? '0 : pos_r;
    ok      = start_of_file | ok_r;
    pos_inc = pos + DataW'(1);
    shifted = {byte_value, asm_r[DataW-1:8]};
    chk     = ok;

    ph_nxt      = ph;
    pos_nxt     = pos;
    ok_nxt      = ok;
    asm_nxt     = asm_r;
    fmt_ext_nxt = fmt_ext_r;
    skip_m1_nxt = skip_m1_r;
    left_nxt    = start_of_file ? '0 : left_r;
    res_valid   = 1'b0;
    res         = '0;

    if (ph == PH_DONE || ph == PH_HALTED) begin
      ph_nxt = ph;
    end else if (no_byte) begin
      res_valid = 1'b1;
      res.kind  = KIND_ERROR;
      ph_nxt    = PH_HALTED;
      unique case (ph)
        PH_MAIN:     res.status = ST_RIFF;
        PH_FMT_HDR:  res.status = ST_FMT_TAG;
        PH_FMT_BODY,
        PH_FMT_SKIP: res.status = ST_FMT_LEN;
        PH_DATA_HDR: res.status = ST_DATA_TAG;
        default:     res.status = ST_TRUNC;
      endcase
    end else begin
      unique case (ph)
        PH_MAIN: begin
          if (pos < DataW'(4)) begin
            if (byte_value != tag_byte(TAG_RIFF, pos[1:0])) chk = 1'b0;
          end else if (pos >= DataW'(8)) begin
            if (byte_value != tag_byte(TAG_WAVE, pos[1:0])) chk = 1'b0;
          end
          if (pos >= DataW'(11)) begin
            if (!chk) begin
              res_valid  = 1'b1;
              res.kind   = KIND_ERROR;
              res.status = ST_RIFF;
              ph_nxt     = PH_HALTED;
            end else begin
              ph_nxt  = PH_FMT_HDR;
              pos_nxt = '0;
              ok_nxt  = 1'b1;
            end
          end else begin
            ok_nxt  = chk;
            pos_nxt = pos_inc;
          end
        end
        PH_FMT_HDR: begin
          if (pos < DataW'(4)) begin
            if (byte_value != tag_byte(TAG_FMT, pos[1:0])) chk = 1'b0;
          end else begin
            asm_nxt = shifted;
          end
          if (pos >= DataW'(7)) begin
            if (!chk) begin
              res_valid  = 1'b1;
              res.kind   = KIND_ERROR;
              res.status = ST_FMT_TAG;
              ph_nxt     = PH_HALTED;
            end else if (shifted < DataW'(16)) begin
              res_valid  = 1'b1;
              res.kind   = KIND_ERROR;
              res.status = ST_FMT_LEN;
              ph_nxt     = PH_HALTED;
            end else begin
              fmt_ext_nxt = (shifted > DataW'(16));
              skip_m1_nxt = shifted - DataW'(17);
              ph_nxt      = PH_FMT_BODY;
              pos_nxt     = '0;
              ok_nxt      = 1'b1;
            end
          end else begin
            ok_nxt  = chk;
            pos_nxt = pos_inc;
          end
        end
        PH_FMT_BODY: begin
          if ((pos == DataW'(0) || pos == DataW'(2)) && byte_value != 8'd1) chk = 1'b0;
          if ((pos == DataW'(1) || pos == DataW'(3) || pos == DataW'(15)) &&
              byte_value != 8'd0) chk = 1'b0;
          if (pos == DataW'(14) && byte_value != 8'd8) chk = 1'b0;
          if (pos >= DataW'(4) && pos <= DataW'(7)) begin
            asm_nxt = shifted;
            if (pos == DataW'(7) && shifted != cfg.rate) chk = 1'b0;
          end
          if (pos >= DataW'(15)) begin
            if (fmt_ext_r) begin
              ph_nxt  = PH_FMT_SKIP;
              pos_nxt = '0;
              ok_nxt  = chk;
            end else if (!chk) begin
              res_valid  = 1'b1;
              res.kind   = KIND_ERROR;
              res.status = ST_FORMAT;
              ph_nxt     = PH_HALTED;
            end else begin
              ph_nxt  = PH_DATA_HDR;
              pos_nxt = '0;
              ok_nxt  = 1'b1;
            end
          end else begin
            ok_nxt  = chk;
            pos_nxt = pos_inc;
          end
        end
        PH_FMT_SKIP: begin
          if (pos >= skip_m1_r) begin
            if (!ok) begin
              res_valid  = 1'b1;
              res.kind   = KIND_ERROR;
              res.status = ST_FORMAT;
              ph_nxt     = PH_HALTED;
            end else begin
              ph_nxt  = PH_DATA_HDR;
              pos_nxt = '0;
              ok_nxt  = 1'b1;
            end
          end else begin
            pos_nxt = pos_inc;
          end
        end
        PH_DATA_HDR: begin
          if (pos < DataW'(4)) begin
            if (byte_value != tag_byte(TAG_DATA, pos[1:0])) chk = 1'b0;
          end else begin
            asm_nxt = shifted;
          end
          if (pos >= DataW'(7)) begin
            if (!chk) begin
              res_valid  = 1'b1;
              res.kind   = KIND_ERROR;
              res.status = ST_DATA_TAG;
              ph_nxt     = PH_HALTED;
            end else begin
              left_nxt  = cfg.samples;
              ph_nxt    = (cfg.samples != '0) ? PH_SAMPLES : PH_DONE;
              pos_nxt   = '0;
              res_valid = 1'b1;
              res.kind  = KIND_HEADER;
              res.count = shifted;
            end
          end else begin
            ok_nxt  = chk;
            pos_nxt = pos_inc;
          end
        end
        default: begin
          left_nxt   = left_r - DataW'(1);
          res_valid  = 1'b1;
          res.kind   = KIND_SAMPLE;
          res.sample = $signed(byte_value ^ SIGN_FLIP);
          res.last   = (left_r == DataW'(1));
          if (left_r == DataW'(1)) ph_nxt = PH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r      <= PH_MAIN;
      pos_r     <= '0;
      ok_r      <= 1'b1;
      fmt_ext_r <= 1'b0;
      skip_m1_r <= '0;
      left_r    <= '0;
    end else if (accept) begin
      ph_r      <= ph_nxt;
      pos_r     <= pos_nxt;
      ok_r      <= ok_nxt;
      fmt_ext_r <= fmt_ext_nxt;
      skip_m1_r <= skip_m1_nxt;
      left_r    <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) asm_r <= asm_nxt;
  end

endmodule

@@ src/wav_pcm8_mono_parser_unit.sv @@
// ----------------------------------------------------------------------------
// wav_pcm8_mono_parser_unit
// Byte-stream parser for 8-bit mono PCM WAV files with sample output.
// ----------------------------------------------------------------------------
//   channel   direction  handshake            beat
//   in_*      input      in_valid / in_stall   one file byte or end-of-file mark
//   out_*     output     out_valid / out_stall header, sample or error result
//   p*        bus        psel / penable        32-bit register write or read
//
// One beat per cycle when not stalled: the parse step is one pass of logic
// from the state registers into the output register. A two-entry output
// stage (output and skid registers) holds results; in_stall rises only when
// both are full. Reset is synchronous and clears parse state and both entries.
// ----------------------------------------------------------------------------
module wav_pcm8_mono_parser_unit
  import wpp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte_value,
  input  logic              in_no_byte,
  input  logic              in_start_of_file,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_result_kind,
  output logic signed [7:0] out_sample_value,
  output logic [DataW-1:0]  out_sample_count,
  output logic [2:0]        out_status,
  output logic              out_last_sample,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  cfg_t cfg;
  logic in_accept;
  logic res_valid;
  res_t res;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r, out_res_nxt;
  logic skd_valid_r, skd_valid_nxt;
  res_t skd_res_r, skd_res_nxt;
  logic out_take;

  wpp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_stall  = skd_valid_r;
  assign in_accept = in_valid & ~skd_valid_r;

  wpp_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .byte_value    (in_byte_value),
    .no_byte       (in_no_byte),
    .start_of_file (in_start_of_file),
    .cfg           (cfg),
    .res_valid     (res_valid),
    .res           (res)
  );

  assign out_take = out_valid_r & ~out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    skd_valid_nxt = skd_valid_r;
    skd_res_nxt   = skd_res_r;
    if (skd_valid_r) begin
      if (out_take) begin
        out_res_nxt   = skd_res_r;
        skd_valid_nxt = 1'b0;
      end
    end else if (in_accept && res_valid) begin
      if (!out_valid_r || out_take) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = res;
      end else begin
        skd_valid_nxt = 1'b1;
        skd_res_nxt   = res;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skd_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skd_valid_r <= skd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    skd_res_r <= skd_res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_res_r.kind;
  assign out_sample_value = out_res_r.sample;
  assign out_sample_count = out_res_r.count;
  assign out_status       = out_res_r.status;
  assign out_last_sample  = out_res_r.last;

endmodule

@@ src/wpp_checker.sv @@
// ----------------------------------------------------------------------------
// wpp_checker
// Port-level checks of the WAV parser, bound to the top level.
// ----------------------------------------------------------------------------
module wpp_checker
  import wpp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_result_kind,
  input logic signed [7:0] out_sample_value,
  input logic [DataW-1:0]  out_sample_count,
  input logic [2:0]        out_status,
  input logic              out_last_sample
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind) &&
      $stable(out_status) && $stable(out_sample_value))
    else $error("stalled result beat changed");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_ERROR |->
      out_status != ST_OK && out_sample_count == '0 && !out_last_sample)
    else $error("error beat with bad fields");

  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_HEADER || out_result_kind == KIND_SAMPLE) |->
      out_status == ST_OK)
    else $error("nonzero status on header or sample");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_sample |-> out_result_kind == KIND_SAMPLE)
    else $error("last flag on a non-sample beat");

  a_stall_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

endmodule

bind wav_pcm8_mono_parser_unit wpp_checker u_wpp_checker (.*);

@@ tb/wav_pcm8_mono_parser_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wav_pcm8_mono_parser_unit_tb
// Feeds whole WAV files, damaged files and loose bytes into the parser one
// beat at a time, tracks the parse in a local model and compares every
// result beat field by field. Runs under several register settings and under
// sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module wav_pcm8_mono_parser_unit_tb;
  import wpp_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam logic [2:0] ADDR_RATE    = {REG_RATE, 2'b00};
  localparam logic [2:0] ADDR_SAMPLES = {REG_SAMPLES, 2'b00};

  typedef enum logic [3:0] {
    PH_MAIN, PH_FMT_HDR, PH_FMT_BODY, PH_FMT_SKIP,
    PH_DATA_HDR, PH_SAMPLES, PH_DONE, PH_HALTED
  } phase_t;

  typedef struct packed {
    logic [7:0] b;
    logic       nob;
    logic       sof;
  } beat_t;

  typedef struct packed {
    beat_t      bt;
    logic       err;
    logic [2:0] status;
  } row_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_byte_value = '0;
  logic              in_no_byte = 1'b0;
  logic              in_start_of_file = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_result_kind;
  logic signed [7:0] out_sample_value;
  logic [DataW-1:0]  out_sample_count;
  logic [2:0]        out_status;
  logic              out_last_sample;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  wav_pcm8_mono_parser_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_value    (in_byte_value),
    .in_no_byte       (in_no_byte),
    .in_start_of_file (in_start_of_file),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_sample_value (out_sample_value),
    .out_sample_count (out_sample_count),
    .out_status       (out_status),
    .out_last_sample  (out_last_sample),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // parse model state and register shadow
  phase_t      st_phase;
  logic [31:0] st_pos;
  logic [31:0] st_word;
  logic [31:0] st_fmt_len;
  logic        st_fmt_ok;
  logic [31:0] st_left;
  cfg_t        reg_shadow;
  bit          pr_got;
  res_t        pr_res;

  res_t        results_due[$];
  beat_t       file_q[$];
  row_t        row_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [7:0] lane(input logic [31:0] w, input logic [1:0] i);
    return w[{i, 3'b000} +: 8];
  endfunction

  task automatic restart_file();
    st_phase   = PH_MAIN;
    st_pos     = '0;
    st_word    = '0;
    st_fmt_len = '0;
    st_fmt_ok  = 1'b1;
    st_left    = '0;
  endtask

  task automatic open_segment(input phase_t ph);
    st_phase  = ph;
    st_pos    = '0;
    st_fmt_ok = 1'b1;
  endtask

  task automatic raise(input logic [2:0] st);
    st_phase      = PH_HALTED;
    pr_got        = 1'b1;
    pr_res        = '0;
    pr_res.kind   = KIND_ERROR;
    pr_res.status = st;
  endtask

  task automatic close_fmt();
    if (!st_fmt_ok) raise(ST_FORMAT);
    else open_segment(PH_DATA_HDR);
  endtask

  task automatic parse_beat(input beat_t bt);
    logic [31:0] pos;
    pr_got = 1'b0;
    pr_res = '0;
    if (bt.sof) restart_file();
    pos = st_pos;
    if (st_phase == PH_DONE || st_phase == PH_HALTED) begin
    end else if (bt.nob) begin
      case (st_phase)
        PH_MAIN:                  raise(ST_RIFF);
        PH_FMT_HDR:               raise(ST_FMT_TAG);
        PH_FMT_BODY, PH_FMT_SKIP: raise(ST_FMT_LEN);
        PH_DATA_HDR:              raise(ST_DATA_TAG);
        default:                  raise(ST_TRUNC);
      endcase
    end else begin
      case (st_phase)
        PH_MAIN: begin
          if (pos < 4) begin
            if (lane(TAGW_RIFF, pos[1:0]) != bt.b) st_fmt_ok = 1'b0;
          end else if (pos >= 8) begin
            if (lane(TAGW_WAVE, pos[1:0]) != bt.b) st_fmt_ok = 1'b0;
          end
          if (pos >= 11) begin
            if (!st_fmt_ok) raise(ST_RIFF);
            else open_segment(PH_FMT_HDR);
          end else begin
            st_pos = pos + 1;
          end
        end
        PH_FMT_HDR: begin
          if (pos < 4) begin
            if (lane(TAGW_FMT, pos[1:0]) != bt.b) st_fmt_ok = 1'b0;
          end else begin
            st_word = {bt.b, st_word[31:8]};
          end
          if (pos >= 7) begin
            if (!st_fmt_ok) raise(ST_FMT_TAG);
            else if (st_word < 16) raise(ST_FMT_LEN);
            else begin
              st_fmt_len = st_word;
              open_segment(PH_FMT_BODY);
            end
          end else begin
            st_pos = pos + 1;
          end
        end
        PH_FMT_BODY: begin
          if ((pos == 0 || pos == 2) && bt.b != 8'd1) st_fmt_ok = 1'b0;
          if ((pos == 1 || pos == 3 || pos == 15) && bt.b != 8'd0) st_fmt_ok = 1'b0;
          if (pos == 14 && bt.b != 8'd8) st_fmt_ok = 1'b0;
          if (pos >= 4 && pos <= 7) begin
            st_word = {bt.b, st_word[31:8]};
            if (pos == 7 && st_word != reg_shadow.rate) st_fmt_ok = 1'b0;
          end
          if (pos >= 15) begin
            if (st_fmt_len <= 16) close_fmt();
            else begin
              st_phase = PH_FMT_SKIP;
              st_pos   = '0;
            end
          end else begin
            st_pos = pos + 1;
          end
        end
        PH_FMT_SKIP: begin
          if (pos + 32'd1 >= st_fmt_len - 32'd16) close_fmt();
          else st_pos = pos + 1;
        end
        PH_DATA_HDR: begin
          if (pos < 4) begin
            if (lane(TAGW_DATA, pos[1:0]) != bt.b) st_fmt_ok = 1'b0;
          end else begin
            st_word = {bt.b, st_word[31:8]};
          end
          if (pos >= 7) begin
            if (!st_fmt_ok) raise(ST_DATA_TAG);
            else begin
              st_left      = reg_shadow.samples;
              st_phase     = (st_left != 0) ? PH_SAMPLES : PH_DONE;
              st_pos       = '0;
              pr_got       = 1'b1;
              pr_res.kind  = KIND_HEADER;
              pr_res.count = st_word;
            end
          end else begin
            st_pos = pos + 1;
          end
        end
        default: begin
          pr_got        = 1'b1;
          pr_res.kind   = KIND_SAMPLE;
          pr_res.sample = bt.b ^ SIGN_FLIP;
          pr_res.last   = (st_left == 32'd1);
          st_left       = st_left - 1;
          if (st_left == 0) st_phase = PH_DONE;
        end
      endcase
    end
  endtask

  task automatic send_beat(input beat_t bt, input bit typed, input res_t want);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_byte_value    <= bt.b;
    in_no_byte       <= bt.nob;
    in_start_of_file <= bt.sof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_beat(bt);
    if (typed) results_due.push_back(want);
    else if (pr_got) results_due.push_back(pr_res);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_RATE) reg_shadow.rate = data;
    else reg_shadow.samples = data;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic add_row(input logic [7:0] b, input logic nob, input logic sof,
                         input logic err, input logic [2:0] status);
    row_t r;
    r.bt.b   = b;
    r.bt.nob = nob;
    r.bt.sof = sof;
    r.err    = err;
    r.status = status;
    row_q.push_back(r);
  endtask

  task automatic push_beat(input logic [7:0] b, input logic nob);
    beat_t bt;
    bt.b   = b;
    bt.nob = nob;
    bt.sof = 1'b0;
    file_q.push_back(bt);
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) push_beat(w[8*i +: 8], 1'b0);
  endtask

  // lay out one file; unless it is to be clean, a random flaw may damage it
  task automatic build_file(input int unsigned n_samples, input bit clean);
    int unsigned extra;
    int unsigned flaw;
    int unsigned k;
    logic [31:0] flen;
    file_q.delete();
    extra = ($urandom_range(3) == 0) ? $urandom_range(1, 5) : 0;
    flen  = 16 + extra;
    flaw  = clean ? 0 : $urandom_range(0, 9);
    if (flaw == 6 || flaw == 7) flen = $urandom_range(0, 15);
    if (flaw == 8) flen = $urandom_range(1) ? 32'hFFFF_FFFF : ($urandom | 32'h0001_0000);
    push_word(TAGW_RIFF);
    push_word($urandom);
    push_word(TAGW_WAVE);
    push_word(TAGW_FMT);
    push_word(flen);
    push_word(32'h0001_0001);
    push_word(reg_shadow.rate);
    push_word($urandom);
    push_beat(8'($urandom), 1'b0);
    push_beat(8'($urandom), 1'b0);
    push_beat(8'd8, 1'b0);
    push_beat(8'd0, 1'b0);
    if (flaw == 8) begin
      repeat (3) push_beat(8'($urandom), 1'b0);
      push_beat(8'($urandom), 1'b1);
    end else begin
      repeat (extra) push_beat(8'($urandom), 1'b0);
      push_word(TAGW_DATA);
      push_word($urandom);
      repeat (n_samples) push_beat(8'($urandom), 1'b0);
      case (flaw)
        3: begin
          k = $urandom_range(0, file_q.size() - 1);
          file_q[k].b = file_q[k].b ^ 8'($urandom_range(1, 255));
        end
        4: begin
          k = $urandom_range(0, file_q.size() - 1);
          while (file_q.size() > k) void'(file_q.pop_back());
          push_beat(8'($urandom), 1'b1);
        end
        5: begin
          k = $urandom_range(1, file_q.size() - 1);
          file_q[k].sof = 1'b1;
        end
        7: begin
          k = 12 + $urandom_range(0, 3);
          file_q[k].b = file_q[k].b ^ 8'($urandom_range(1, 255));
        end
        9: begin
          k = 20 + $urandom_range(0, 15);
          file_q[k].b = file_q[k].b ^ 8'($urandom_range(1, 255));
        end
        default: ;
      endcase
      if ($urandom_range(3) == 0) push_beat(8'($urandom), 1'b1);
    end
    file_q[0].sof = ($urandom_range(19) != 0);
  endtask

  task automatic flag_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got kind %0d status %0d", $time,
                 out_result_kind, out_status);
        errors++;
      end else begin
        want = results_due.pop_front();
        flag_field("kind", 32'(want.kind), 32'(out_result_kind));
        flag_field("sample", 32'(unsigned'(want.sample)), 32'(unsigned'(out_sample_value)));
        flag_field("count", want.count, out_sample_count);
        flag_field("status", 32'(want.status), 32'(out_status));
        flag_field("last", 32'(want.last), 32'(out_last_sample));
      end
    end
  end

  initial begin
    int unsigned send_pcts[4];
    int unsigned stall_pcts[4];
    logic [31:0] rate_set[4];
    logic [31:0] cnt_set[4];
    int unsigned sent;
    int unsigned lim;
    logic [31:0] val;
    res_t        typed_res;

    send_pcts  = '{0, 46, 0, 32};
    stall_pcts = '{0, 0, 46, 32};
    rate_set   = '{32'hFFFF_FFFF, 32'd0, RATE_RESET, $urandom};
    cnt_set    = '{32'hFFFF_FFFF, 32'd0, 32'd3, $urandom_range(2, 8)};
    reg_shadow.rate    = RATE_RESET;
    reg_shadow.samples = SAMPLES_RESET;
    restart_file();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_row(8'h00, 1'b1, 1'b1, 1'b1, ST_RIFF);
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, ST_OK);
    add_row(8'h00, 1'b1, 1'b0, 1'b0, ST_OK);
    add_row("R",   1'b0, 1'b1, 1'b0, ST_OK);
    add_row("I",   1'b0, 1'b0, 1'b0, ST_OK);
    add_row("F",   1'b0, 1'b0, 1'b0, ST_OK);
    add_row("F",   1'b0, 1'b0, 1'b0, ST_OK);
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, ST_OK);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, ST_OK);
    add_row(8'h7F, 1'b0, 1'b0, 1'b0, ST_OK);
    add_row(8'h80, 1'b0, 1'b0, 1'b0, ST_OK);
    add_row("W",   1'b0, 1'b0, 1'b0, ST_OK);
    add_row("A",   1'b0, 1'b0, 1'b0, ST_OK);
    add_row("V",   1'b0, 1'b0, 1'b0, ST_OK);
    add_row("X",   1'b0, 1'b0, 1'b1, ST_RIFF);
    add_row("R",   1'b0, 1'b1, 1'b0, ST_OK);
    add_row("I",   1'b0, 1'b0, 1'b0, ST_OK);
    add_row("F",   1'b0, 1'b0, 1'b0, ST_OK);
    add_row("F",   1'b0, 1'b0, 1'b0, ST_OK);
    add_row(8'hA5, 1'b1, 1'b0, 1'b1, ST_RIFF);
    add_row(8'h5A, 1'b1, 1'b0, 1'b0, ST_OK);

    foreach (row_q[i]) begin
      typed_res        = '0;
      typed_res.kind   = KIND_ERROR;
      typed_res.status = row_q[i].status;
      send_beat(row_q[i].bt, row_q[i].err, typed_res);
    end
    drain();

    // hold the receiver off while a long sample run backs up into the input
    reg_write(ADDR_SAMPLES, 32'd40);
    @(posedge clk);
    hold_req++;
    build_file(40, 1'b1);
    file_q[0].sof = 1'b1;
    foreach (file_q[i]) send_beat(file_q[i], 1'b0, typed_res);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_pcts[ph];
      stall_pct     = stall_pcts[ph];
      reg_write(ADDR_RATE, rate_set[ph]);
      reg_write(ADDR_SAMPLES, cnt_set[ph]);
      sent = 0;
      while (sent < 80) begin
        if ($urandom_range(3) == 0) begin
          drain();
          case ($urandom_range(4))
            0:       val = RATE_RESET;
            1:       val = '0;
            2:       val = '1;
            3:       val = 32'd44100;
            default: val = $urandom;
          endcase
          reg_write(ADDR_RATE, val);
          case ($urandom_range(3))
            0:       val = '0;
            1:       val = 32'd1;
            2:       val = '1;
            default: val = $urandom_range(2, 8);
          endcase
          reg_write(ADDR_SAMPLES, val);
        end else if ($urandom_range(4) == 0) begin
          drain();
        end
        if ($urandom_range(5) == 0) begin
          file_q.delete();
          repeat ($urandom_range(1, 3)) push_beat(8'($urandom), 1'($urandom_range(1)));
          foreach (file_q[i]) send_beat(file_q[i], 1'b0, typed_res);
        end
        lim = (reg_shadow.samples > 10) ? 10 : reg_shadow.samples;
        build_file($urandom_range(0, lim + 2), 1'b0);
        foreach (file_q[i]) send_beat(file_q[i], 1'b0, typed_res);
        sent += file_q.size();
      end
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/wpp_pkg.sv
src/wpp_regs.sv
src/wpp_core.sv
src/wav_pcm8_mono_parser_unit.sv
src/wpp_checker.sv
tb/wav_pcm8_mono_parser_unit_tb.sv
